// ===== hw/rtl/frame_header_deframer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the frame header deframer
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef FRAME_HEADER_DEFRAMER_ASSERT_SVH
`define FRAME_HEADER_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FHD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame header deframer: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame header deframer: assertion failed");

`endif

// ===== hw/rtl/fhd_pkg.sv =====
// ---------------------------------------------------------------------------
// fhd_pkg
// Shared widths, header layout, result codes and register indexes.
// ---------------------------------------------------------------------------
package fhd_pkg;

   // Payload widths
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned CODE_W      = 3;
   localparam int unsigned SEQ_W       = 64;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   // Header layout
   localparam int unsigned HDR_BYTES   = 48;
   localparam int unsigned HDR_BITS    = HDR_BYTES * BYTE_W;
   localparam int unsigned HDR_CNT_W   = 6;
   localparam logic [31:0] HDR_MAGIC   = 32'h4d32_5446;
   localparam logic [7:0]  HDR_VERSION = 8'd1;

   // Byte offsets of header fields
   localparam int unsigned OFF_MAGIC    = 0;
   localparam int unsigned OFF_VERSION  = 4;
   localparam int unsigned OFF_BITS     = 5;
   localparam int unsigned OFF_SENDER   = 6;
   localparam int unsigned OFF_RECEIVER = 7;
   localparam int unsigned OFF_PHASE    = 8;
   localparam int unsigned OFF_TYPE     = 9;
   localparam int unsigned OFF_RSVD     = 10;
   localparam int unsigned OFF_N        = 12;
   localparam int unsigned OFF_K        = 16;
   localparam int unsigned OFF_LENGTH   = 20;
   localparam int unsigned OFF_SESSION  = 24;
   localparam int unsigned OFF_FPRINT   = 32;
   localparam int unsigned OFF_SEQ      = 40;

   // Default payload limit
   localparam int unsigned FHD_MAX_PAYLOAD = 1 << 20;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   // Error codes, in priority order
   localparam logic [CODE_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [CODE_W-1:0] ERR_FORMAT   = 3'd1;
   localparam logic [CODE_W-1:0] ERR_MISMATCH = 3'd2;
   localparam logic [CODE_W-1:0] ERR_SEQUENCE = 3'd3;
   localparam logic [CODE_W-1:0] ERR_LENGTH   = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_N    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_K    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_BITS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_ID      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_ID       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MESSAGE_CLASS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SESSION_ID    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FINGERPRINT   = 3'd7;

endpackage

// ===== hw/rtl/fhd_channels_if.sv =====
// ---------------------------------------------------------------------------
// fhd channel interfaces
// Valid/ready request channel (stream bytes) and response channel (results).
// ---------------------------------------------------------------------------
interface fhd_req_if import fhd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface fhd_rsp_if import fhd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [BYTE_W-1:0] payload_byte;
   logic              last_of_frame;
   logic [CODE_W-1:0] error_code;
   logic [SEQ_W-1:0]  frame_index;

   modport source (output valid, output result_kind, output payload_byte,
                   output last_of_frame, output error_code, output frame_index,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input last_of_frame, input error_code, input frame_index,
                   output ready);
endinterface

// ===== hw/rtl/frame_header_deframer.sv =====
// ---------------------------------------------------------------------------
// frame_header_deframer
// Parses 48-byte frame headers from a byte stream, checks them against the
// control registers and a running frame counter, then forwards the payload.
// ---------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                        Moves
//   req_ch   in   data_byte                                      1 stream byte
//   rsp_ch   out  result_kind, payload_byte, last_of_frame,      0 or 1 result
//                 error_code, frame_index                        per request
//   csr_*    in   csr_index, csr_wdata                           1 register write
//
// One request per cycle. Each request is handled in the cycle it is taken;
// its result, if any, appears in the response register on the next cycle.
// The full header check runs on the cycle the 48th header byte arrives, over
// the header shift line plus the incoming byte.
// Requests stall only while the response register holds an untaken result.
// Synchronous reset returns to header parsing with the frame counter at zero.
//
`include "frame_header_deframer_assert.svh"

module frame_header_deframer import fhd_pkg::*; #(
   parameter int unsigned MAX_PAYLOAD = FHD_MAX_PAYLOAD
) (
   input  logic                  clock,
   input  logic                  reset,
   fhd_req_if.sink               req_ch,
   fhd_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned REM_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [HDR_CNT_W-1:0] LAST_HDR_IDX = HDR_CNT_W'(HDR_BYTES - 1);
   localparam logic [31:0] MAX_LEN = 32'(MAX_PAYLOAD);

   typedef enum logic [1:0] {
      ST_HEADER,
      ST_PAYLOAD,
      ST_FAILED
   } stage_type;

   // Control registers
   logic [31:0] exp_n_ff;
   logic [31:0] exp_k_ff;
   logic [5:0]  exp_bits_ff;
   logic [1:0]  local_id_ff;
   logic [1:0]  peer_id_ff;
   logic [15:0] msg_class_ff;
   logic [63:0] session_ff;
   logic [63:0] fprint_ff;

   // Parser state
   stage_type               stage_ff, stage_in;
   logic [HDR_CNT_W-1:0]    hdr_cnt_ff, hdr_cnt_in;
   logic [REM_W-1:0]        remain_ff, remain_in;
   logic [SEQ_W-1:0]        exp_seq_ff, exp_seq_in;
   logic [HDR_BYTES-1:0][BYTE_W-1:0] hdr_ff, hdr_in;

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]       rsp_byte_ff, rsp_byte_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [CODE_W-1:0]       rsp_code_ff, rsp_code_in;
   logic [SEQ_W-1:0]        rsp_index_ff, rsp_index_in;

   logic                    req_ready;
   logic                    req_fire;
   logic                    rsp_load;
   logic [HDR_BITS-1:0]     hdr_full;
   logic [31:0]             hdr_length;
   logic [CODE_W-1:0]       hdr_code;
   logic                    fmt_bad;
   logic                    field_bad;
   logic                    last_byte;

   // Handshake: take a request unless a result is stuck in the register
   assign req_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   // Header as it stands once the incoming byte is shifted in; first byte on top
   assign hdr_full   = {hdr_ff[HDR_BYTES-2:0], req_ch.data_byte};
   assign hdr_length = hdr_full[HDR_BITS-1-8*OFF_LENGTH -: 32];

   // Header checks
   assign fmt_bad =
      (hdr_full[HDR_BITS-1-8*OFF_MAGIC -: 32] != HDR_MAGIC) ||
      (hdr_full[HDR_BITS-1-8*OFF_VERSION -: 8] != HDR_VERSION) ||
      (hdr_full[HDR_BITS-1-8*OFF_RSVD -: 16] != 16'd0);

   assign field_bad =
      (hdr_full[HDR_BITS-1-8*OFF_N -: 32] != exp_n_ff) ||
      (hdr_full[HDR_BITS-1-8*OFF_K -: 32] != exp_k_ff) ||
      (hdr_full[HDR_BITS-1-8*OFF_SESSION -: 64] != session_ff) ||
      (hdr_full[HDR_BITS-1-8*OFF_FPRINT -: 64] != fprint_ff) ||
      (hdr_full[HDR_BITS-1-8*OFF_BITS -: 8] != {2'd0, exp_bits_ff}) ||
      (hdr_full[HDR_BITS-1-8*OFF_SENDER -: 8] != {6'd0, peer_id_ff}) ||
      (hdr_full[HDR_BITS-1-8*OFF_RECEIVER -: 8] != {6'd0, local_id_ff}) ||
      (hdr_full[HDR_BITS-1-8*OFF_PHASE -: 8] != msg_class_ff[15:8]) ||
      (hdr_full[HDR_BITS-1-8*OFF_TYPE -: 8] != msg_class_ff[7:0]);

   always_comb begin
      priority if (fmt_bad) begin
         hdr_code = ERR_FORMAT;
      end else if (field_bad) begin
         hdr_code = ERR_MISMATCH;
      end else if (hdr_full[HDR_BITS-1-8*OFF_SEQ -: 64] != exp_seq_ff) begin
         hdr_code = ERR_SEQUENCE;
      end else if (hdr_length > MAX_LEN) begin
         hdr_code = ERR_LENGTH;
      end else begin
         hdr_code = ERR_NONE;
      end
   end

   assign last_byte = (remain_ff <= REM_W'(1));

   // Next-state and result logic
   always_comb begin
      stage_in     = stage_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      remain_in    = remain_ff;
      exp_seq_in   = exp_seq_ff;
      hdr_in       = hdr_ff;
      rsp_load     = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_index_in = rsp_index_ff;

      if (req_fire) begin
         unique case (stage_ff)
            ST_HEADER: begin
               hdr_in = hdr_full;
               if (hdr_cnt_ff == LAST_HDR_IDX) begin
                  hdr_cnt_in = '0;
                  if (hdr_code != ERR_NONE) begin
                     rsp_load     = 1'b1;
                     rsp_kind_in  = KIND_ERROR;
                     rsp_byte_in  = '0;
                     rsp_last_in  = 1'b0;
                     rsp_code_in  = hdr_code;
                     rsp_index_in = exp_seq_ff;
                     stage_in     = ST_FAILED;
                  end else if (hdr_length == 32'd0) begin
                     rsp_load     = 1'b1;
                     rsp_kind_in  = KIND_EMPTY;
                     rsp_byte_in  = '0;
                     rsp_last_in  = 1'b1;
                     rsp_code_in  = ERR_NONE;
                     rsp_index_in = exp_seq_ff;
                     exp_seq_in   = exp_seq_ff + SEQ_W'(1);
                  end else begin
                     remain_in = hdr_length[REM_W-1:0];
                     stage_in  = ST_PAYLOAD;
                  end
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + HDR_CNT_W'(1);
               end
            end
            ST_PAYLOAD: begin
               rsp_load     = 1'b1;
               rsp_kind_in  = KIND_PAYLOAD;
               rsp_byte_in  = req_ch.data_byte;
               rsp_last_in  = last_byte;
               rsp_code_in  = ERR_NONE;
               rsp_index_in = exp_seq_ff;
               if (last_byte) begin
                  remain_in  = '0;
                  exp_seq_in = exp_seq_ff + SEQ_W'(1);
                  stage_in   = ST_HEADER;
               end else begin
                  remain_in = remain_ff - REM_W'(1);
               end
            end
            ST_FAILED: begin
               // silent until reset
            end
            default: begin
               stage_in = ST_FAILED;
            end
         endcase
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_index_ff <= rsp_index_in;
      if (reset) begin
         stage_ff     <= ST_HEADER;
         hdr_cnt_ff   <= '0;
         remain_ff    <= '0;
         exp_seq_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_ff     <= stage_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         remain_ff    <= remain_in;
         exp_seq_ff   <= exp_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_n_ff     <= 32'd1;
         exp_k_ff     <= 32'd1;
         exp_bits_ff  <= 6'd34;
         local_id_ff  <= 2'd0;
         peer_id_ff   <= 2'd1;
         msg_class_ff <= 16'd257;
         session_ff   <= '0;
         fprint_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXPECTED_N:    exp_n_ff     <= csr_wdata[31:0];
            CSR_EXPECTED_K:    exp_k_ff     <= csr_wdata[31:0];
            CSR_EXPECTED_BITS: exp_bits_ff  <= csr_wdata[5:0];
            CSR_LOCAL_ID:      local_id_ff  <= csr_wdata[1:0];
            CSR_PEER_ID:       peer_id_ff   <= csr_wdata[1:0];
            CSR_MESSAGE_CLASS: msg_class_ff <= csr_wdata[15:0];
            CSR_SESSION_ID:    session_ff   <= csr_wdata;
            CSR_FINGERPRINT:   fprint_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Response port
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_kind   = rsp_kind_ff;
   assign rsp_ch.payload_byte  = rsp_byte_ff;
   assign rsp_ch.last_of_frame = rsp_last_ff;
   assign rsp_ch.error_code    = rsp_code_ff;
   assign rsp_ch.frame_index   = rsp_index_ff;

   // Checks
   `FHD_ASSERT_NOW(a_failed_silent, clock, reset, stage_ff == ST_FAILED, !rsp_load)
   `FHD_ASSERT_NOW(a_payload_remaining, clock, reset, stage_ff == ST_PAYLOAD,
      remain_ff != '0)
   `FHD_ASSERT_NOW(a_hdr_count_range, clock, reset, 1'b1, hdr_cnt_ff <= LAST_HDR_IDX)
   `FHD_ASSERT_NEXT(a_seq_step, clock, reset, 1'b1,
      (exp_seq_ff == $past(exp_seq_ff)) || (exp_seq_ff == $past(exp_seq_ff) + SEQ_W'(1)))
   `FHD_ASSERT_NEXT(a_error_fails, clock, reset,
      rsp_load && (rsp_kind_in == KIND_ERROR), stage_ff == ST_FAILED)

endmodule
